// ===== rtl/dcsync_pkg.sv =====
// shared types and constants for the distributed clock pi sync block
`default_nettype none

package dcsync_pkg;

    localparam int REF_W     = 63;
    localparam int CFG_W     = 30;
    localparam int OFS_W     = 32;
    localparam int PHASE_W   = 31;
    localparam int CNT_W     = 7;
    localparam int INTEG_W   = 32;

    localparam logic [CFG_W-1:0] CYCLE_TIME_RESET  = 30'd1000000;
    localparam logic [CFG_W-1:0] SYNC_OFFSET_RESET = 30'd50000;

    // delta / 100 as (delta * ceil(2^37 / 100)) >> 37, exact below 2^30
    localparam int                 RECIP_W     = 31;
    localparam int                 DELTA_SHIFT = 37;
    localparam logic [RECIP_W-1:0] DELTA_RECIP = 31'd1374389535;

    // integral / 20 kept as a running quotient and remainder
    localparam int                        INTEG_DIV = 20;
    localparam int                        IREM_W    = 6;
    localparam logic signed [IREM_W-1:0]  IREM_TOP  = IREM_W'(INTEG_DIV - 1);
    localparam logic signed [IREM_W-1:0]  IREM_BOT  = -IREM_TOP;

    localparam logic REG_CYCLE_TIME  = 1'b0;
    localparam logic REG_SYNC_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ADJ,
        S_INTEG,
        S_SUM
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic busy;
    } t_div_sts;

endpackage

`default_nettype wire

// ===== rtl/dcsync_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module dcsync_div #(
    parameter int DW = dcsync_pkg::REF_W
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  dcsync_pkg::t_div_req                 i_req,
    input  wire  [DW-1:0]                        i_dividend,
    input  wire  [dcsync_pkg::CFG_W-1:0]         i_divisor,
    output dcsync_pkg::t_div_sts                 o_sts,
    output logic [dcsync_pkg::CFG_W-1:0]         o_remainder
);

    logic [dcsync_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0]                r_quo, n_quo;
    logic [dcsync_pkg::CFG_W-1:0] r_rem, n_rem;
    logic [dcsync_pkg::CFG_W-1:0] r_div, n_div;
    logic [dcsync_pkg::CFG_W:0]   rem_sh;
    logic [dcsync_pkg::CFG_W:0]   rem_sub;
    logic                         fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = (rem_sh >= {1'b0, r_div});
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_req.start) begin
            n_cnt = i_req.iters;
            n_quo = i_dividend;
            n_rem = '0;
            n_div = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_quo = {r_quo[DW-2:0], fits};
            n_rem = fits ? rem_sub[dcsync_pkg::CFG_W-1:0] : rem_sh[dcsync_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_sts.busy  = (r_cnt != '0);
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== rtl/dc_clock_sync_pi.sv =====
// distributed clock pi phase lock: phase error, integral and period correction
// a request runs the divider for the cycle-time remainder, then ADJ, INTEG and SUM
// (straight to INTEG when the cycle time is zero); the divider yields one bit per cycle
// the next request is taken once the result is registered; SUM holds while an untaken result
// fills the output register, and a finished result waits there while the next request is taken
// synchronous active-low reset clears the integral, the state and the registers to defaults
`default_nettype none

module dc_clock_sync_pi #(
    parameter int INTEGRAL_WIDTH = dcsync_pkg::INTEG_W
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire                                   i_cfg_index,
    input  wire  [dcsync_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [dcsync_pkg::REF_W-1:0]          i_ref_time,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [dcsync_pkg::OFS_W-1:0]   o_time_offset,
    output logic signed [dcsync_pkg::PHASE_W-1:0] o_phase_error
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam int DW = dcsync_pkg::REF_W;
    localparam int CW = ((IW > dcsync_pkg::OFS_W) ? IW : dcsync_pkg::OFS_W) + 2;
    localparam int FW = dcsync_pkg::CFG_W;
    localparam int PW = dcsync_pkg::PHASE_W;
    localparam int RW = dcsync_pkg::RECIP_W;
    localparam int RMW = dcsync_pkg::IREM_W;

    localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic signed [CW-1:0] OMAX = {{(CW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [CW-1:0] OMIN = {{(CW-31){1'b1}}, {31{1'b0}}};

    dcsync_pkg::t_state   r_state, n_state;
    dcsync_pkg::t_div_req div_req;
    dcsync_pkg::t_div_sts div_sts;

    logic [DW-1:0]           div_dividend;
    logic [FW-1:0]           div_divisor;
    logic [FW-1:0]           div_rem;

    logic [FW-1:0]           r_cycle_time, r_sync_offset;
    logic signed [IW-1:0]    r_integ, n_integ;
    logic signed [IW-1:0]    r_iq, n_iq;
    logic signed [RMW-1:0]   r_ir, n_ir;
    logic                    r_neg, n_neg;
    logic signed [PW-1:0]    r_delta, n_delta;
    logic [FW-1:0]           r_qd, n_qd;
    logic                    r_out_valid, n_out_valid;
    logic signed [dcsync_pkg::OFS_W-1:0] r_time_offset, n_time_offset;
    logic signed [PW-1:0]    r_phase_error, n_phase_error;

    logic [dcsync_pkg::REF_W-1:0] mag_pos;
    logic [FW-1:0]           mag_neg;
    logic                    ref_lt;
    logic signed [PW-1:0]    delta_neg;
    logic [PW-1:0]           delta_mag;
    logic [FW+RW-1:0]        qd_prod;
    logic signed [CW-1:0]    term_d, term_i, corr;

    always_comb begin
        mag_pos   = i_ref_time - dcsync_pkg::REF_W'(r_sync_offset);
        mag_neg   = r_sync_offset - i_ref_time[FW-1:0];
        ref_lt    = (i_ref_time < dcsync_pkg::REF_W'(r_sync_offset));
        delta_neg = -$signed({1'b0, div_rem});
        delta_mag = r_delta[PW-1] ? PW'(-r_delta) : PW'(r_delta);
        qd_prod   = {{RW{1'b0}}, delta_mag[FW-1:0]} * {{FW{1'b0}}, dcsync_pkg::DELTA_RECIP};
        term_d    = r_delta[PW-1] ? $signed(CW'(r_qd)) : -$signed(CW'(r_qd));
        term_i    = -$signed({{(CW-IW){r_iq[IW-1]}}, r_iq});
        corr      = term_d + term_i;

        n_state       = r_state;
        n_integ       = r_integ;
        n_iq          = r_iq;
        n_ir          = r_ir;
        n_neg         = r_neg;
        n_delta       = r_delta;
        n_qd          = r_qd;
        n_out_valid   = r_out_valid && !i_ready;
        n_time_offset = r_time_offset;
        n_phase_error = r_phase_error;
        div_req.start = 1'b0;
        div_req.iters = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        o_ready       = 1'b0;

        case (r_state)
            dcsync_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_neg = ref_lt;
                    if (r_cycle_time != '0) begin
                        div_req.start = 1'b1;
                        div_req.iters = dcsync_pkg::CNT_W'(dcsync_pkg::REF_W);
                        div_dividend  = ref_lt ? DW'(mag_neg) : DW'(mag_pos);
                        div_divisor   = r_cycle_time;
                        n_state       = dcsync_pkg::S_MOD;
                    end else begin
                        n_delta = '0;
                        n_state = dcsync_pkg::S_INTEG;
                    end
                end
            end
            dcsync_pkg::S_MOD: begin
                if (!div_sts.busy) begin
                    n_delta = r_neg ? delta_neg : $signed({1'b0, div_rem});
                    n_state = dcsync_pkg::S_ADJ;
                end
            end
            dcsync_pkg::S_ADJ: begin
                if (r_delta > $signed({2'b00, r_cycle_time[FW-1:1]})) begin
                    n_delta = r_delta - $signed({1'b0, r_cycle_time});
                end
                n_state = dcsync_pkg::S_INTEG;
            end
            dcsync_pkg::S_INTEG: begin
                if (r_delta > 0 && r_integ != IMAX) begin
                    n_integ = r_integ + 1'b1;
                    if (r_ir == dcsync_pkg::IREM_TOP) begin
                        n_iq = r_iq + 1'b1;
                        n_ir = '0;
                    end else if (r_ir == '0 && r_integ[IW-1]) begin
                        n_iq = r_iq + 1'b1;
                        n_ir = dcsync_pkg::IREM_BOT;
                    end else begin
                        n_ir = r_ir + 1'b1;
                    end
                end else if (r_delta < 0 && r_integ != IMIN) begin
                    n_integ = r_integ - 1'b1;
                    if (r_ir == dcsync_pkg::IREM_BOT) begin
                        n_iq = r_iq - 1'b1;
                        n_ir = '0;
                    end else if (r_ir == '0 && !r_integ[IW-1] && r_integ != '0) begin
                        n_iq = r_iq - 1'b1;
                        n_ir = dcsync_pkg::IREM_TOP;
                    end else begin
                        n_ir = r_ir - 1'b1;
                    end
                end
                n_qd    = FW'(qd_prod >> dcsync_pkg::DELTA_SHIFT);
                n_state = dcsync_pkg::S_SUM;
            end
            dcsync_pkg::S_SUM: begin
                if (!r_out_valid || i_ready) begin
                    if (corr > OMAX) begin
                        n_time_offset = OMAX[dcsync_pkg::OFS_W-1:0];
                    end else if (corr < OMIN) begin
                        n_time_offset = OMIN[dcsync_pkg::OFS_W-1:0];
                    end else begin
                        n_time_offset = corr[dcsync_pkg::OFS_W-1:0];
                    end
                    n_phase_error = r_delta;
                    n_out_valid   = 1'b1;
                    n_state       = dcsync_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcsync_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcsync_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_time  <= dcsync_pkg::CYCLE_TIME_RESET;
            r_sync_offset <= dcsync_pkg::SYNC_OFFSET_RESET;
            r_integ       <= '0;
            r_iq          <= '0;
            r_ir          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == dcsync_pkg::REG_CYCLE_TIME) begin
                r_cycle_time <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == dcsync_pkg::REG_SYNC_OFFSET) begin
                r_sync_offset <= i_cfg_data;
            end
            r_integ     <= n_integ;
            r_iq        <= n_iq;
            r_ir        <= n_ir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg         <= n_neg;
        r_delta       <= n_delta;
        r_qd          <= n_qd;
        r_time_offset <= n_time_offset;
        r_phase_error <= n_phase_error;
    end

    dcsync_div #(
        .DW (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_sts       (div_sts),
        .o_remainder (div_rem)
    );

    assign o_valid       = r_out_valid;
    assign o_time_offset = r_time_offset;
    assign o_phase_error = r_phase_error;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_phase_half_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcsync_pkg::S_INTEG)
        |-> (r_delta <= $signed({2'b00, r_cycle_time[FW-1:1]})))
        else $error("phase error above half a cycle");

    a_integ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcsync_pkg::S_SUM && $past(r_state) == dcsync_pkg::S_INTEG)
        |-> (r_integ == $past(r_integ) || r_integ == $past(r_integ) + 1'b1
             || r_integ == $past(r_integ) - 1'b1))
        else $error("integral moved by more than one");

    a_integ_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ir <= dcsync_pkg::IREM_TOP && r_ir >= dcsync_pkg::IREM_BOT))
        else $error("integral remainder out of range");

endmodule

`default_nettype wire

// ===== verif/tb_dc_clock_sync_pi.sv =====
// self-checking testbench for the distributed clock pi phase lock block
module tb_dc_clock_sync_pi;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INTEG_BITS = dcsync_pkg::INTEG_W;
    localparam int STALL_LIMIT = 5000;
    localparam int BLOCK_ITEMS = 40;
    localparam logic [dcsync_pkg::CFG_W-1:0] CFG_MAX = '1;

    typedef struct packed {
        logic [dcsync_pkg::OFS_W-1:0]   time_offset;
        logic [dcsync_pkg::PHASE_W-1:0] phase_error;
    } t_corr;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic                             i_cfg_index = dcsync_pkg::REG_CYCLE_TIME;
    logic [dcsync_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [dcsync_pkg::REF_W-1:0]     i_ref_time = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic signed [dcsync_pkg::OFS_W-1:0]   o_time_offset;
    logic signed [dcsync_pkg::PHASE_W-1:0] o_phase_error;

    dc_clock_sync_pi u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ref_time    (i_ref_time),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_time_offset (o_time_offset),
        .o_phase_error (o_phase_error)
    );

    // local copy of the block's registers and integral
    logic [dcsync_pkg::CFG_W-1:0] cycle_ns = dcsync_pkg::CYCLE_TIME_RESET;
    logic [dcsync_pkg::CFG_W-1:0] offset_ns = dcsync_pkg::SYNC_OFFSET_RESET;
    longint           integ_acc = 0;

    t_corr pending_corr[$];
    t_corr head_corr;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int n_cfg_writes = 0;
    int n_drains = 0;
    int cfg_pick = 0;
    int drift_ns = 0;
    int stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void predict_correction(input logic [dcsync_pkg::REF_W-1:0] t,
                                               output t_corr res);
        longint diff;
        longint cyc;
        longint err;
        longint corr;
        longint imax;
        longint imin;
        cyc  = longint'({34'd0, cycle_ns});
        diff = longint'({1'b0, t}) - longint'({34'd0, offset_ns});
        imax = longint'({1'b0, {63{1'b1}}} >> (64 - INTEG_BITS));
        imin = -imax - 1;
        err  = 0;
        if (cyc != 0) begin
            err = diff % cyc;
            if (err > cyc / 2) begin
                err = err - cyc;
            end
        end
        if (err > 0 && integ_acc < imax) begin
            integ_acc = integ_acc + 1;
        end
        if (err < 0 && integ_acc > imin) begin
            integ_acc = integ_acc - 1;
        end
        corr = -(err / 100) - (integ_acc / 20);
        if (corr > 64'sd2147483647) begin
            corr = 64'sd2147483647;
        end
        if (corr < -64'sd2147483648) begin
            corr = -64'sd2147483648;
        end
        res.time_offset = corr[dcsync_pkg::OFS_W-1:0];
        res.phase_error = err[dcsync_pkg::PHASE_W-1:0];
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_corr.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected result: time_offset %0d phase_error %0d",
                             o_time_offset, o_phase_error);
                end
            end else begin
                head_corr = pending_corr.pop_front();
                n_checked++;
                if (o_time_offset !== head_corr.time_offset ||
                    o_phase_error !== head_corr.phase_error) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result %0d: time_offset exp %0d got %0d, phase_error exp %0d got %0d",
                                 n_checked, $signed(head_corr.time_offset), o_time_offset,
                                 $signed(head_corr.phase_error), o_phase_error);
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results pending",
                     stall_cycles, pending_corr.size());
            $display("tb_dc_clock_sync_pi: FAIL");
            $finish;
        end
    end

    task automatic send_sample(input logic [dcsync_pkg::REF_W-1:0] t);
        t_corr res;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_ref_time <= t;
        do @(posedge i_clk); while (!o_ready);
        predict_correction(t, res);
        pending_corr.push_back(res);
        n_sent++;
    endtask

    // stop requesting and wait for every pending result
    task automatic quiesce();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_corr.size() != 0);
        n_drains++;
    endtask

    task automatic write_reg(input logic idx, input logic [dcsync_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dcsync_pkg::REG_CYCLE_TIME) begin
            cycle_ns = val;
        end else begin
            offset_ns = val;
        end
        n_cfg_writes++;
    endtask

    task automatic set_timing(input logic [dcsync_pkg::CFG_W-1:0] cyc,
                              input logic [dcsync_pkg::CFG_W-1:0] ofs);
        quiesce();
        write_reg(dcsync_pkg::REG_CYCLE_TIME, cyc);
        write_reg(dcsync_pkg::REG_SYNC_OFFSET, ofs);
    endtask

    function automatic logic [dcsync_pkg::REF_W-1:0] pick_ref_time();
        logic [dcsync_pkg::REF_W-1:0] base;
        logic [dcsync_pkg::REF_W-1:0] jit;
        int sel;
        int span;
        sel = $urandom_range(99);
        if (sel < 65 && cycle_ns != 0) begin
            // near the sync point, with a slowly wandering drift
            base = dcsync_pkg::REF_W'({$urandom, $urandom} >> 3);
            base = base - (base % {33'd0, cycle_ns});
            if ($urandom_range(15) == 0) begin
                drift_ns = 0;
            end
            drift_ns = drift_ns + int'($urandom_range(20)) - 10;
            span = (cycle_ns < 30'd400) ? int'(cycle_ns) : 200;
            jit = dcsync_pkg::REF_W'(longint'(drift_ns) + longint'($urandom_range(span))
                                     - span / 2);
            return base + {33'd0, offset_ns} + jit;
        end else if (sel < 80) begin
            return dcsync_pkg::REF_W'($urandom_range(0, 2 * int'(offset_ns[28:0]) + 10));
        end else begin
            return dcsync_pkg::REF_W'({$urandom, $urandom});
        end
    endfunction

    task automatic test_reset_defaults();
        send_sample(63'd50000);
        send_sample(63'd0);
        send_sample(63'd550000);
        send_sample(63'd550001);
        send_sample(63'd1049999);
        send_sample({dcsync_pkg::REF_W{1'b1}});
    endtask

    task automatic test_register_extremes();
        set_timing(CFG_MAX, CFG_MAX);
        send_sample(63'd0);
        send_sample({33'd0, CFG_MAX - 30'd1});
        send_sample({dcsync_pkg::REF_W{1'b1}});
        set_timing(30'd1000, 30'd0);
        send_sample(63'd999);
        send_sample(63'd500);
        send_sample(63'd501);
        send_sample(63'd0);
    endtask

    task automatic test_zero_cycle();
        set_timing(30'd0, 30'd777);
        send_sample(63'd0);
        send_sample(63'd12345);
        send_sample({dcsync_pkg::REF_W{1'b1}});
    endtask

    task automatic test_tiny_cycles();
        set_timing(30'd3, 30'd0);
        send_sample(63'd1);
        send_sample(63'd2);
        send_sample(63'd4);
        set_timing(30'd1, 30'd5);
        send_sample(63'd3);
        set_timing(30'd2, 30'd0);
        send_sample(63'd1);
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
        logic [dcsync_pkg::CFG_W-1:0] cyc;
        logic [dcsync_pkg::CFG_W-1:0] ofs;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % BLOCK_ITEMS == 0) begin
                case (cfg_pick % 6)
                    0: begin
                        cyc = dcsync_pkg::CYCLE_TIME_RESET;
                        ofs = dcsync_pkg::SYNC_OFFSET_RESET;
                    end
                    1: begin cyc = 30'd1000; ofs = 30'd0; end
                    2: begin cyc = CFG_MAX; ofs = CFG_MAX; end
                    3: begin cyc = 30'd0; ofs = dcsync_pkg::CFG_W'($urandom); end
                    4: begin
                        cyc = dcsync_pkg::CFG_W'($urandom_range(1, 5000));
                        ofs = dcsync_pkg::CFG_W'($urandom_range(0, 10000));
                    end
                    default: begin
                        cyc = dcsync_pkg::CFG_W'($urandom);
                        ofs = dcsync_pkg::CFG_W'($urandom);
                    end
                endcase
                cfg_pick++;
                drift_ns = 0;
                set_timing(cyc, ofs);
            end else if ($urandom_range(49) == 0) begin
                // hold off until the block has drained
                quiesce();
            end
            send_sample(pick_ref_time());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 29;
        rcv_idle_pct = 58;
        test_reset_defaults();
        test_register_extremes();
        test_zero_cycle();
        test_tiny_cycles();
        test_random_traffic(29, 58, 240);
        test_random_traffic(58, 29, 240);
        test_random_traffic(0, 0, 240);
        quiesce();
        repeat (200) @(posedge i_clk);
        $display("checked %0d of %0d samples across %0d register writes and %0d drains",
                 n_checked, n_sent, n_cfg_writes, n_drains);
        $display("timing sets: defaults, extremes, zero and tiny cycles, random; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0 && pending_corr.size() == 0) begin
            $display("tb_dc_clock_sync_pi: PASS");
        end else begin
            $display("tb_dc_clock_sync_pi: FAIL");
        end
        $finish;
    end

endmodule
